// ===== src/joystick_calibrate_quantize_unit_assert.svh =====
// Assertion macros for the joystick calibrate-and-quantize unit checker.
// Included by the checker file only; depends on nothing else.
`ifndef JOYSTICK_CALIBRATE_QUANTIZE_UNIT_ASSERT_SVH
`define JOYSTICK_CALIBRATE_QUANTIZE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCQ_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCQ_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== src/jcq_pkg.sv =====
// Shared types, constants and the level quantizer of the joystick unit.
// No dependencies; imported by every module of the block.
package jcq_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int AXES        = 4;
    localparam int AX_YAW      = 0;
    localparam int AX_THROTTLE = 1;
    localparam int AX_ROLL     = 2;
    localparam int AX_PITCH    = 3;

    localparam int PCT_W   = 7;                  // percent 0..99
    localparam int PROD_W  = SAMPLE_BITS + PCT_W;
    localparam int OFS_W   = 8;                  // signed offset -99..127
    localparam int SUM_W   = 9;                  // signed corrected value
    localparam int LEVEL_W = 4;
    localparam int COUNT_W = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int QPROD_W = PCT_W + 8;

    localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
    localparam logic [PCT_W-1:0]   MAX_PERCENT = 7'd100;
    localparam logic [PCT_W-1:0]   ROUND_BIAS  = 7'd5;
    localparam logic [7:0]         RECIP_10    = 8'd205;  // 2048 / 10, rounded up
    localparam int                 RECIP_SHIFT = 11;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_CENTER = 4'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_CAL_SCANS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER    = 1'd1;
    localparam logic [COUNT_W-1:0]     CAL_SCANS_RESET = 4'd3;
    localparam logic [PCT_W-1:0]       CENTER_RESET    = 7'd50;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] yaw_sample;
        logic [SAMPLE_BITS-1:0] throttle_sample;
        logic [SAMPLE_BITS-1:0] roll_sample;
        logic [SAMPLE_BITS-1:0] pitch_sample;
    } scan_t;

    typedef struct packed {
        level_t yaw_level;
        level_t throttle_level;
        level_t roll_level;
        level_t pitch_level;
    } levels_t;

    typedef struct packed {
        logic   slew;        // move one step per scan toward the target
        level_t init_level;  // level set at the end of calibration
    } axis_mode_t;

    typedef struct packed {
        logic             advance;  // load the percent stage
        logic             fire;     // stage two consumes its scan
        logic             capture;  // calibration scan: store offsets
        logic             init;     // last calibration scan: set levels
        logic [PCT_W-1:0] center;
    } lane_ctrl_t;

    typedef struct packed {
        logic   changed;
        level_t level_next;
    } lane_status_t;

    localparam axis_mode_t AXIS_MODE [AXES] = '{
        '{slew: 1'b0, init_level: LEVEL_CENTER},
        '{slew: 1'b1, init_level: LEVEL_MIN},
        '{slew: 1'b0, init_level: LEVEL_CENTER},
        '{slew: 1'b0, init_level: LEVEL_CENTER}
    };

    // Round a corrected value to a level: negative gives 0, above 100 gives 10,
    // else (v + 5) / 10 through a reciprocal multiply, exact for 0..105.
    function automatic level_t quantize(logic signed [SUM_W-1:0] v);
        logic [PCT_W-1:0]   rounded;
        logic [QPROD_W-1:0] prod;
        level_t             q;
        rounded = '0;
        prod    = '0;
        if (v[SUM_W-1]) begin
            q = LEVEL_MIN;
        end else if (v > $signed({2'b00, MAX_PERCENT})) begin
            q = LEVEL_MAX;
        end else begin
            rounded = v[PCT_W-1:0] + ROUND_BIAS;
            prod    = QPROD_W'(rounded) * QPROD_W'(RECIP_10);
            q       = prod[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
        end
        return q;
    endfunction

endpackage

// ===== src/joystick_calibrate_quantize_unit.sv =====
// Top level of the joystick calibrate-and-quantize unit: four axis lanes and
// the merge stage. Depends on jcq_pkg, jcq_lane and jcq_merge.
//
// Usage:
//   scan channel (scan_valid/scan_ready/scan) takes one scan of four raw
//   samples; levels channel (level_valid/level_ready/levels) returns the four
//   levels whenever a scan changed at least one of them.
//   cfg_wr_en/cfg_index/cfg_data write calibration_scans (index 0) and
//   center_percent (index 1); write only while idle.
//   The first calibration_scans scans capture per-axis offsets and give no
//   result; the last of them sets the levels to 5, 0, 5, 5.
//   Path: an accepted scan is registered in the percent stage, then in the result register.
//   Throughput: one scan per cycle unless the result stalls, set by the level
//   registers, which quantize and update behind a registered percent stage.
//   Reset: configuration returns to 3 scans and 50 percent, offsets, levels
//   and the scan count clear, and the pipeline empties.
//   Stall: a waiting result holds steady; one more scan is taken into the
//   percent stage, after which scan_ready drops until the result is taken.
module joystick_calibrate_quantize_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [jcq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jcq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            scan_valid,
    output logic                            scan_ready,
    input  jcq_pkg::scan_t                  scan,
    output logic                            level_valid,
    input  logic                            level_ready,
    output jcq_pkg::levels_t                levels
);
    import jcq_pkg::*;

    logic [SAMPLE_BITS-1:0]   samples [AXES];
    lane_status_t [AXES-1:0]  status;
    lane_ctrl_t               ctrl;

    always_comb
    begin
        samples[AX_YAW]      = scan.yaw_sample;
        samples[AX_THROTTLE] = scan.throttle_sample;
        samples[AX_ROLL]     = scan.roll_sample;
        samples[AX_PITCH]    = scan.pitch_sample;
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        jcq_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .sample (samples[i]),
            .mode   (AXIS_MODE[i]),
            .ctrl   (ctrl),
            .status (status[i])
        );
    end

    jcq_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .scan_valid  (scan_valid),
        .scan_ready  (scan_ready),
        .level_valid (level_valid),
        .level_ready (level_ready),
        .levels      (levels),
        .status      (status),
        .ctrl        (ctrl)
    );

endmodule

// ===== src/jcq_lane.sv =====
// One axis lane: percent stage, stored offset, quantizer and level register.
// Depends on jcq_pkg.
module jcq_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [jcq_pkg::SAMPLE_BITS-1:0] sample,
    input  jcq_pkg::axis_mode_t             mode,
    input  jcq_pkg::lane_ctrl_t             ctrl,
    output jcq_pkg::lane_status_t           status
);
    import jcq_pkg::*;

    logic [PROD_W-1:0]       product;
    logic [PCT_W-1:0]        pct_reg;
    logic [PCT_W-1:0]        pct_next;
    logic signed [OFS_W-1:0] offset_reg;
    logic signed [OFS_W-1:0] offset_next;
    logic signed [SUM_W-1:0] corrected;
    level_t                  target;
    level_t                  level_reg;
    level_t                  level_next;
    logic                    changed;

    always_comb
    begin
        product  = PROD_W'(sample) * PROD_W'(PCT_SCALE);
        pct_next = product[PROD_W-1:SAMPLE_BITS];
    end

    always_comb
    begin
        offset_next = $signed({1'b0, ctrl.center}) - $signed({1'b0, pct_reg});
        corrected   = $signed({offset_reg[OFS_W-1], offset_reg})
                      + $signed({2'b00, pct_reg});
        target      = quantize(corrected);
        level_next  = level_reg;
        changed     = 1'b0;
        if (mode.slew) begin
            if (target > level_reg) begin
                if (level_reg < LEVEL_MAX)
                begin
                    level_next = level_reg + 1'b1;
                end
                changed = 1'b1;
            end else if (target < level_reg) begin
                if (level_reg > LEVEL_MIN)
                begin
                    level_next = level_reg - 1'b1;
                end
                changed = 1'b1;
            end
        end else if (target != level_reg) begin
            level_next = target;
            changed    = 1'b1;
        end
        status.changed    = changed;
        status.level_next = level_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            pct_reg <= pct_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            level_reg  <= '0;
        end
        else if (ctrl.capture)
        begin
            offset_reg <= offset_next;
            if (ctrl.init)
            begin
                level_reg <= mode.init_level;
            end
        end
        else if (ctrl.fire)
        begin
            level_reg <= level_next;
        end
    end

endmodule

// ===== src/jcq_merge.sv =====
// Merge stage: config registers, calibration count, handshake control and
// the result register that combines the four lanes. Depends on jcq_pkg.
module jcq_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [jcq_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [jcq_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   scan_valid,
    output logic                                   scan_ready,
    output logic                                   level_valid,
    input  logic                                   level_ready,
    output jcq_pkg::levels_t                       levels,
    input  jcq_pkg::lane_status_t [jcq_pkg::AXES-1:0] status,
    output jcq_pkg::lane_ctrl_t                    ctrl
);
    import jcq_pkg::*;

    logic [COUNT_W-1:0] cal_scans_reg;
    logic [PCT_W-1:0]   center_reg;
    logic [COUNT_W-1:0] scans_seen_reg;
    logic [COUNT_W-1:0] seen_inc;
    logic               stage_valid_reg;
    logic               out_valid_reg;
    levels_t            out_reg;
    logic               out_free;
    logic               fire;
    logic               calibrating;
    logic               any_changed;
    logic               produce;

    always_comb
    begin
        out_free    = !out_valid_reg || level_ready;
        fire        = stage_valid_reg && out_free;
        scan_ready  = !stage_valid_reg || out_free;
        calibrating = scans_seen_reg < cal_scans_reg;
        seen_inc    = scans_seen_reg + 1'b1;
        any_changed = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            any_changed = any_changed | status[i].changed;
        end
        produce      = !calibrating && any_changed;
        ctrl.advance = scan_valid && scan_ready;
        ctrl.fire    = fire;
        ctrl.capture = fire && calibrating;
        ctrl.init    = fire && calibrating && (seen_inc == cal_scans_reg);
        ctrl.center  = center_reg;
        level_valid  = out_valid_reg;
        levels       = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_scans_reg <= CAL_SCANS_RESET;
            center_reg    <= CENTER_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CAL_SCANS: cal_scans_reg <= cfg_data[COUNT_W-1:0];
                REG_CENTER:    center_reg    <= cfg_data[PCT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scans_seen_reg  <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                scans_seen_reg <= seen_inc;
            end
            if (ctrl.advance)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                stage_valid_reg <= 1'b0;
            end
            // a consumed scan either refills the result or leaves it empty
            if (fire)
            begin
                out_valid_reg <= produce;
            end
            else if (level_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            out_reg.yaw_level      <= status[AX_YAW].level_next;
            out_reg.throttle_level <= status[AX_THROTTLE].level_next;
            out_reg.roll_level     <= status[AX_ROLL].level_next;
            out_reg.pitch_level    <= status[AX_PITCH].level_next;
        end
    end

endmodule

// ===== src/jcq_checker.sv =====
// Port-level checker for the joystick unit and its bind to the top level.
// Depends on jcq_pkg and joystick_calibrate_quantize_unit_assert.svh.
`include "joystick_calibrate_quantize_unit_assert.svh"

module jcq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             scan_ready,
    input logic             level_valid,
    input logic             level_ready,
    input jcq_pkg::levels_t levels
);
    import jcq_pkg::*;

    // every level of a delivered request stays within 0..10
    `JCQ_ASSERT_IMPLY(a_level_range, clk, rst_n, level_valid,
        (levels.yaw_level <= LEVEL_MAX) && (levels.throttle_level <= LEVEL_MAX) &&
        (levels.roll_level <= LEVEL_MAX) && (levels.pitch_level <= LEVEL_MAX),
        "level out of range")

    // input backs up only behind a stalled result
    `JCQ_ASSERT_IMPLY(a_ready_stall, clk, rst_n, !scan_ready,
        level_valid && !level_ready, "scan_ready low without output stall")

    // hold a stalled result
    `JCQ_ASSERT_NEXT(a_result_hold, clk, rst_n, level_valid && !level_ready,
        level_valid && $stable(levels), "stalled result changed")

endmodule

bind joystick_calibrate_quantize_unit jcq_checker u_checker (.*);
